// File: src/lcs_pkg.sv
// Shared types and constants for the LCS length engine.
`default_nettype none

package lcs_pkg;

   localparam int MAX_LEN_DEF   = 32;
   localparam int CHAR_BITS_DEF = 8;
   localparam int LEN_W         = 6;
   localparam int LEN_SAT       = 63;

   typedef enum logic [1:0] {
      REQ_APPEND_A = 2'd0,
      REQ_APPEND_B = 2'd1,
      REQ_COMPUTE  = 2'd2
   } lcs_req_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROW,
      CORE_CELL,
      CORE_DONE
   } lcs_core_state_type;

   // Commands from the front end to the table core.
   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic start;
      logic take;
   } lcs_ctl_type;

endpackage : lcs_pkg

`default_nettype wire

// File: src/lcs_if.sv
// Request and response channel interfaces of the LCS length engine.
`default_nettype none

interface lcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] ch;

   modport source (output valid, output req_type, output ch, input ready);
   modport sink (input valid, input req_type, input ch, output ready);
endinterface : lcs_req_if

interface lcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] lcs_len;
   logic       overflow;

   modport source (output valid, output lcs_len, output overflow, input ready);
   modport sink (input valid, input lcs_len, input overflow, output ready);
endinterface : lcs_rsp_if

`default_nettype wire

// File: src/lcs_cell_unit.sv
// Shared cell evaluator: diagonal plus one on a match, else the larger neighbor.
`default_nettype none

module lcs_cell_unit #(
   parameter int VAL_W = 6
) (
   input  wire logic             match,
   input  wire logic [VAL_W-1:0] diag,
   input  wire logic [VAL_W-1:0] up,
   input  wire logic [VAL_W-1:0] left,
   output logic      [VAL_W-1:0] cell_val
);

   always_comb begin
      if (match) begin
         cell_val = diag + VAL_W'(1);
      end else if (up > left) begin
         cell_val = up;
      end else begin
         cell_val = left;
      end
   end

endmodule : lcs_cell_unit

`default_nettype wire

// File: src/lcs_core.sv
// String memories, row memory and the sequencer that walks the table cell by cell.
`default_nettype none

module lcs_core #(
   parameter int MAX_LEN   = 32,
   parameter int CHAR_BITS = 8,
   parameter int CNT_W     = $clog2(MAX_LEN + 1),
   parameter int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lcs_pkg::lcs_ctl_type ctl,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire logic [CHAR_BITS-1:0] wr_data,
   input  wire logic [CNT_W-1:0]     len_a,
   input  wire logic [CNT_W-1:0]     len_b,
   output logic                      done,
   output logic [lcs_pkg::LEN_W-1:0] result
);
   import lcs_pkg::*;

   localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   logic [CHAR_BITS-1:0] mem_a [MAX_LEN];
   logic [CHAR_BITS-1:0] mem_b [MAX_LEN];
   logic [CNT_W-1:0]     mem_row [MAX_LEN];

   lcs_core_state_type state_ff, state_in;

   logic [CNT_W-1:0]     n_ff, m_ff, i_ff, j_ff;
   logic [IDX_W-1:0]     wj_ff;
   logic                 pv_ff;
   logic [CNT_W-1:0]     left_ff, diag_ff;
   logic [CHAR_BITS-1:0] a_rd_ff, b_rd_ff;
   logic [CNT_W-1:0]     row_rd_ff;
   logic [LEN_W-1:0]     res_ff;

   logic             row_start, issue, evaluate;
   logic             last_cell, last_row, empty_in;
   logic [CNT_W-1:0] up, cell_val;
   logic [EXT_W-1:0] cell_ext;
   logic [LEN_W-1:0] cell_sat;

   assign empty_in  = (len_a == '0) || (len_b == '0);
   assign last_cell = (CNT_W'(wj_ff) + CNT_W'(1)) == m_ff;
   assign last_row  = (i_ff + CNT_W'(1)) == n_ff;

   // The row memory still holds the previous compute on the first row.
   assign up = (i_ff == '0) ? '0 : row_rd_ff;

   lcs_cell_unit #(
      .VAL_W (CNT_W)
   ) u_cell (
      .match    (a_rd_ff == b_rd_ff),
      .diag     (diag_ff),
      .up       (up),
      .left     (left_ff),
      .cell_val (cell_val)
   );

   assign cell_ext = EXT_W'(cell_val);
   assign cell_sat = (cell_ext > EXT_W'(LEN_SAT)) ? LEN_W'(LEN_SAT) : cell_ext[LEN_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CORE_IDLE: begin
            if (ctl.start) begin
               state_in = empty_in ? CORE_DONE : CORE_ROW;
            end
         end
         CORE_ROW: begin
            state_in = CORE_CELL;
         end
         CORE_CELL: begin
            if (evaluate && last_cell) begin
               state_in = last_row ? CORE_DONE : CORE_ROW;
            end
         end
         CORE_DONE: begin
            if (ctl.take) begin
               state_in = CORE_IDLE;
            end
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   always_comb begin
      row_start = (state_ff == CORE_ROW);
      issue     = (state_ff == CORE_CELL) && (j_ff < m_ff);
      evaluate  = (state_ff == CORE_CELL) && pv_ff;
      done      = (state_ff == CORE_DONE);
   end

   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         pv_ff    <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= issue;
         if (state_ff == CORE_IDLE && ctl.start) begin
            i_ff <= '0;
         end else if (evaluate && last_cell) begin
            i_ff <= i_ff + CNT_W'(1);
         end
         if (row_start) begin
            j_ff <= '0;
         end else if (issue) begin
            j_ff <= j_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == CORE_IDLE && ctl.start) begin
         n_ff   <= len_a;
         m_ff   <= len_b;
         res_ff <= '0;
      end
      if (row_start) begin
         left_ff <= '0;
         diag_ff <= '0;
      end else if (evaluate) begin
         left_ff <= cell_val;
         diag_ff <= up;
         if (last_cell && last_row) begin
            res_ff <= cell_sat;
         end
      end
      if (issue) begin
         wj_ff <= j_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (row_start) begin
         a_rd_ff <= mem_a[i_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (issue) begin
         b_rd_ff <= mem_b[j_ff[IDX_W-1:0]];
      end
   end

   // A cell is written in the cycle after its read; the read in that cycle is always a different entry.
   always_ff @(posedge clock) begin
      if (evaluate) begin
         mem_row[wj_ff] <= cell_val;
      end
      if (issue) begin
         row_rd_ff <= mem_row[j_ff[IDX_W-1:0]];
      end
   end

endmodule : lcs_core

`default_nettype wire

// File: src/lcs_length_engine_top.sv
// Top level of the LCS length engine: request decode, string counters and result register.
`default_nettype none

// Characters are appended to string A or string B one per transaction, up to MAX_LEN
// per string; further characters are dropped and reported through the overflow bit of
// the next result. A compute transaction evaluates the table with a single cell unit,
// one cell per cycle within a row, against a row memory: each row of string A opens
// with a row-start state, and the result is registered after the last cell of the last
// row (the core goes straight to done when either string is empty). The request side is
// not ready while the compute runs, and stays not ready while an earlier result still
// waits in the result register. The result register lets new appends be accepted while
// a result waits. A compute clears both strings and the overflow flag.
// The length saturates at 63.
module lcs_length_engine_top #(
   parameter int MAX_LEN   = lcs_pkg::MAX_LEN_DEF,
   parameter int CHAR_BITS = lcs_pkg::CHAR_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   lcs_req_if.sink  req_ch,
   lcs_rsp_if.source rsp_ch
);
   import lcs_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [CNT_W-1:0] cnt_a_ff, cnt_b_ff;
   logic             dropped_ff, ovf_pend_ff, busy_ff;
   logic             rsp_valid_ff, rsp_ovf_ff;
   logic [LEN_W-1:0] rsp_len_ff;

   lcs_ctl_type      ctl;
   logic             req_fire, is_a, is_b, is_comp, full_a, full_b;
   logic             core_done;
   logic [LEN_W-1:0] core_result;
   logic [IDX_W-1:0] wr_addr;

   assign req_ch.ready = !busy_ff;
   assign req_fire     = req_ch.valid && !busy_ff;

   always_comb begin
      is_a    = 1'b0;
      is_b    = 1'b0;
      is_comp = 1'b0;
      unique case (lcs_req_type'(req_ch.req_type))
         REQ_APPEND_A: is_a    = 1'b1;
         REQ_APPEND_B: is_b    = 1'b1;
         REQ_COMPUTE:  is_comp = 1'b1;
         default: begin
            is_a = 1'b0;
         end
      endcase
   end

   assign full_a = (cnt_a_ff == CNT_W'(MAX_LEN));
   assign full_b = (cnt_b_ff == CNT_W'(MAX_LEN));

   always_comb begin
      ctl.wr_a  = req_fire && is_a && !full_a;
      ctl.wr_b  = req_fire && is_b && !full_b;
      ctl.start = req_fire && is_comp;
      ctl.take  = core_done && (!rsp_valid_ff || rsp_ch.ready);
   end

   assign wr_addr = is_b ? cnt_b_ff[IDX_W-1:0] : cnt_a_ff[IDX_W-1:0];

   lcs_core #(
      .MAX_LEN   (MAX_LEN),
      .CHAR_BITS (CHAR_BITS),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .wr_data (CHAR_BITS'(req_ch.ch)),
      .len_a   (cnt_a_ff),
      .len_b   (cnt_b_ff),
      .done    (core_done),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.start) begin
            cnt_a_ff   <= '0;
            cnt_b_ff   <= '0;
            dropped_ff <= 1'b0;
            busy_ff    <= 1'b1;
         end else begin
            if (ctl.wr_a) begin
               cnt_a_ff <= cnt_a_ff + CNT_W'(1);
            end
            if (ctl.wr_b) begin
               cnt_b_ff <= cnt_b_ff + CNT_W'(1);
            end
            if (req_fire && ((is_a && full_a) || (is_b && full_b))) begin
               dropped_ff <= 1'b1;
            end
         end
         if (ctl.take) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         ovf_pend_ff <= dropped_ff;
      end
      if (ctl.take) begin
         rsp_len_ff <= core_result;
         rsp_ovf_ff <= ovf_pend_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.lcs_len  = rsp_len_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

endmodule : lcs_length_engine_top

`default_nettype wire
